// ===== rtl/dve_pkg.sv =====
// Shared types and constants of the divisor enumerator.
package dve_pkg;

  // Width of the number and divisor fields on the ports.
  localparam int FIELD_BITS = 13;
  // Default number of low bits of the input that are used.
  localparam int NUMBER_BITS_DEF = 13;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_PUSH_D,
    ST_PUSH_Q
  } dve_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_start;
    logic push_d;
    logic push_q;
    logic advance;
    logic flush;
  } dve_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sq_le_n;
    logic div_done;
    logic rem_zero;
    logic q_eq_d;
  } dve_stat_t;

endpackage

// ===== rtl/dve_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
module dve_divider import dve_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF,
  parameter int TRIAL_BITS  = (NUMBER_BITS + 1) / 2 + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [NUMBER_BITS-1:0] dividend,
  input  logic [TRIAL_BITS-1:0]  divisor,
  output logic                   done,
  output logic [NUMBER_BITS-1:0] quotient,
  output logic [TRIAL_BITS-1:0]  remainder
);

  localparam int CNT_BITS = (NUMBER_BITS > 1) ? $clog2(NUMBER_BITS) : 1;

  logic [NUMBER_BITS-1:0] quo_r, quo_nxt;
  logic [TRIAL_BITS-1:0]  rem_r, rem_nxt;
  logic [TRIAL_BITS-1:0]  div_r;
  logic [CNT_BITS-1:0]    cnt_r;
  logic                   run_r;
  logic                   done_r;
  logic [TRIAL_BITS:0]    trial;
  logic [TRIAL_BITS:0]    diff;
  logic                   ge;

  always_comb begin
    trial   = {rem_r, quo_r[NUMBER_BITS-1]};
    diff    = trial - {1'b0, div_r};
    ge      = (trial >= {1'b0, div_r});
    rem_nxt = ge ? diff[TRIAL_BITS-1:0] : trial[TRIAL_BITS-1:0];
    quo_nxt = {quo_r[NUMBER_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(NUMBER_BITS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/dve_datapath.sv =====
// Datapath: held number, trial divisor and its square, divider and result buffer.
module dve_datapath import dve_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [FIELD_BITS-1:0] in_number,
  input  dve_cmd_t              cmd,
  output dve_stat_t             stat,
  output logic                  out_valid,
  output logic [FIELD_BITS-1:0] out_divisor,
  output logic                  out_last
);

  localparam int TRIAL_BITS = (NUMBER_BITS + 1) / 2 + 1;
  localparam int SQ_BITS    = 2 * TRIAL_BITS;

  logic [NUMBER_BITS-1:0] n_r;
  logic [TRIAL_BITS-1:0]  d_r;
  logic [SQ_BITS-1:0]     sq_r;
  logic [NUMBER_BITS-1:0] pend_r, pend_nxt;
  logic                   pend_valid_r, pend_valid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [NUMBER_BITS-1:0] out_div_r, out_div_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   div_done;
  logic [NUMBER_BITS-1:0] quotient;
  logic [TRIAL_BITS-1:0]  remainder;
  logic                   push;
  logic [NUMBER_BITS-1:0] push_val;

  dve_divider #(
    .NUMBER_BITS (NUMBER_BITS),
    .TRIAL_BITS  (TRIAL_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (n_r),
    .divisor   (d_r),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  always_comb begin
    stat.sq_le_n  = (sq_r <= SQ_BITS'(n_r));
    stat.div_done = div_done;
    stat.rem_zero = (remainder == '0);
    stat.q_eq_d   = (quotient == NUMBER_BITS'(d_r));
  end

  // One divisor is held back so the final one can be flagged when the search ends.
  always_comb begin
    push     = cmd.push_d | cmd.push_q;
    push_val = cmd.push_q ? quotient : NUMBER_BITS'(d_r);

    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = 1'b0;
    out_div_nxt    = pend_r;
    out_last_nxt   = 1'b0;

    if (cmd.load) begin
      pend_valid_nxt = 1'b0;
    end else if (push) begin
      out_valid_nxt  = pend_valid_r;
      pend_nxt       = push_val;
      pend_valid_nxt = 1'b1;
    end else if (cmd.flush) begin
      out_valid_nxt  = pend_valid_r;
      out_last_nxt   = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      d_r          <= TRIAL_BITS'(1);
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cmd.load) begin
        d_r <= TRIAL_BITS'(1);
      end else if (cmd.advance) begin
        d_r <= d_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_div_r  <= out_div_nxt;
    out_last_r <= out_last_nxt;
    if (cmd.load) begin
      n_r  <= in_number[NUMBER_BITS-1:0];
      sq_r <= SQ_BITS'(1);
    end else if (cmd.advance) begin
      // (d+1)^2 = d^2 + 2d + 1
      sq_r <= sq_r + SQ_BITS'({d_r, 1'b1});
    end
  end

  assign out_valid   = out_valid_r;
  assign out_divisor = FIELD_BITS'(out_div_r);
  assign out_last    = out_last_r & out_valid_r;

endmodule

// ===== rtl/dve_ctrl.sv =====
// Controller state machine that sequences the trial divisions.
module dve_ctrl import dve_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  dve_stat_t stat,
  output dve_cmd_t  cmd,
  output logic      busy
);

  dve_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = stat.sq_le_n ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (stat.div_done) state_nxt = stat.rem_zero ? ST_PUSH_D : ST_CHECK;
      end
      ST_PUSH_D: begin
        state_nxt = stat.q_eq_d ? ST_CHECK : ST_PUSH_Q;
      end
      ST_PUSH_Q: begin
        state_nxt = ST_CHECK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CHECK: begin
        cmd.div_start = stat.sq_le_n;
        cmd.flush     = !stat.sq_le_n;
      end
      ST_DIV: begin
        cmd.advance = stat.div_done & !stat.rem_zero;
      end
      ST_PUSH_D: begin
        cmd.push_d  = 1'b1;
        cmd.advance = stat.q_eq_d;
      end
      ST_PUSH_Q: begin
        cmd.push_q  = 1'b1;
        cmd.advance = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/divisor_enumerator.sv =====
// Top level of the divisor enumerator: controller plus datapath.
//
// A request is a number on in_number, taken at a rising clock edge where start
// is high and busy is low. Only the low NUMBER_BITS bits of in_number are used.
// The block then lists every divisor of that number on out_divisor, one per
// cycle in which out_valid is high. Divisors come in pairs: a trial divisor d
// and then its cofactor n/d, in ascending order of d, and the cofactor is left
// out when it equals d. The final divisor of a request carries out_last.
// A request for zero produces no results at all.
//
// Trial divisors d = 1, 2, 3 and so on are tried while d*d <= n. Each trial
// takes a compare step and then a division in the bit-serial divider, and a
// divisor pair adds one or two push steps. After a request is taken, busy
// stays high until the search ends. One divisor is held back so that the
// last flag can be set, so the final result appears in the first cycle in
// which busy is low.
//
// The receiver cannot stall the result channel: every strobe is a result.
// Reset is synchronous and active low; it returns the block to idle with no
// result pending.
module divisor_enumerator import dve_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [FIELD_BITS-1:0] in_number,
  output logic                  out_valid,
  output logic [FIELD_BITS-1:0] out_divisor,
  output logic                  out_last
);

  dve_cmd_t  cmd;
  dve_stat_t stat;

  // The controller owns sequencing; the datapath owns every stored data value.
  dve_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  dve_datapath #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_number   (in_number),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_divisor (out_divisor),
    .out_last    (out_last)
  );

endmodule

// ===== rtl/dve_checker.sv =====
// Port-level checks of the divisor enumerator and their binding.
module dve_checker import dve_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [FIELD_BITS-1:0] out_divisor,
  input logic                  out_last
);

  // The last flag only ever marks a real result.
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("out_last without out_valid");

  // Zero is never a divisor.
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_divisor != '0))
    else $error("zero divisor emitted");

  // An accepted request keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // The final result ends the burst.
  a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result after the last one");

  // Reset leaves the block idle with no result.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

endmodule

bind divisor_enumerator dve_checker u_dve_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_divisor (out_divisor),
  .out_last    (out_last)
);
